// ===== rtl/b2da_pkg.sv =====
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared widths, constants and types for the binary to decimal ASCII unit.
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int VALUE_BITS = 64;
  // Decimal digits needed for VALUE_BITS bits: floor(VALUE_BITS * log10(2)) + 1.
  localparam int NUM_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int BIT_CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  localparam logic [5:0] ASCII_ZERO = 6'd48;

  typedef logic [3:0] bcd_t;

  typedef struct packed {
    logic clear;
    logic shift_bin;
    logic shift_dig;
  } cell_ctrl_t;

endpackage

// ===== rtl/b2da_cell.sv =====
// ----------------------------------------------------------------------------
// b2da_cell
// One BCD digit of the conversion chain: add-three correction and shift in
// conversion, digit hand-over towards the most significant end in output.
// ----------------------------------------------------------------------------
module b2da_cell (
  input  logic                 clk,
  input  b2da_pkg::cell_ctrl_t ctrl,
  input  logic                 bit_in,
  input  b2da_pkg::bcd_t       digit_in,
  output logic                 carry_out,
  output b2da_pkg::bcd_t       digit
);

  b2da_pkg::bcd_t adj;

  always_comb begin
    adj = (digit >= 4'd5) ? digit + 4'd3 : digit;
  end

  assign carry_out = adj[3];

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.shift_bin) begin
      digit <= {adj[2:0], bit_in};
    end else if (ctrl.shift_dig) begin
      digit <= digit_in;
    end
  end

endmodule

// ===== rtl/b2da_chain.sv =====
// ----------------------------------------------------------------------------
// b2da_chain
// Row of BCD cells, least significant digit at index zero. Binary bits enter
// at the bottom; digits leave from the top.
// ----------------------------------------------------------------------------
module b2da_chain (
  input  logic                 clk,
  input  b2da_pkg::cell_ctrl_t ctrl,
  input  logic                 bit_in,
  output b2da_pkg::bcd_t       top_digit
);

  logic                 carry [b2da_pkg::NUM_DIGITS+1];
  b2da_pkg::bcd_t       dig   [b2da_pkg::NUM_DIGITS+1];

  assign carry[0] = bit_in;
  assign dig[0]   = '0;

  for (genvar i = 0; i < b2da_pkg::NUM_DIGITS; i++) begin : g_cell
    b2da_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .bit_in    (carry[i]),
      .digit_in  (dig[i]),
      .carry_out (carry[i+1]),
      .digit     (dig[i+1])
    );
  end

  assign top_digit = dig[b2da_pkg::NUM_DIGITS];

endmodule

// ===== rtl/binary_to_decimal_ascii_unit.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit
// Converts an unsigned binary value to decimal ASCII digits, most significant
// first, without leading zeros.
//
//   channel | handshake                  | payload
//   --------+----------------------------+------------------------
//   input   | value_valid / value_ready  | value
//   output  | digit_valid / digit_ready  | digit_char, last_digit
//
// One item is taken in its transfer cycle, then shifted one bit per cycle
// through the cell row for all VALUE_BITS (64) bits, then shifted out one
// digit position (of 20) per cycle while the output is not stalled, leading
// zeros being skipped at one per cycle. A stalled output holds the digit
// shift. Reset is synchronous and clears control state only. A new value is
// taken once the last digit has been loaded into the output register.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        value_valid,
  output logic        value_ready,
  input  logic [63:0] value,
  output logic        digit_valid,
  input  logic        digit_ready,
  output logic [5:0]  digit_char,
  output logic        last_digit
);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_EMIT} state_t;

  state_t                              state;
  logic [b2da_pkg::VALUE_BITS-1:0]     sreg;
  logic [b2da_pkg::BIT_CNT_W-1:0]      bits_left;
  logic [b2da_pkg::DIG_CNT_W-1:0]      digs_left;
  logic                                started;
  b2da_pkg::cell_ctrl_t                ctrl;
  b2da_pkg::bcd_t                      top_digit;
  logic                                slot_free;
  logic                                skip;
  logic                                emit;

  assign value_ready = (state == S_IDLE);
  assign slot_free   = !digit_valid || digit_ready;
  assign skip        = !started && (top_digit == 4'd0) &&
                       (digs_left != b2da_pkg::DIG_CNT_W'(1));
  assign emit        = (state == S_EMIT) && slot_free && !skip;

  always_comb begin
    ctrl.clear     = value_valid && value_ready;
    ctrl.shift_bin = (state == S_CONV);
    ctrl.shift_dig = (state == S_EMIT) && slot_free;
  end

  b2da_chain u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .bit_in    (sreg[b2da_pkg::VALUE_BITS-1]),
    .top_digit (top_digit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      digit_valid <= 1'b0;
      started     <= 1'b0;
    end else begin
      if (digit_valid && digit_ready && !emit) begin
        digit_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (value_valid) begin
            sreg      <= value[b2da_pkg::VALUE_BITS-1:0];
            bits_left <= b2da_pkg::BIT_CNT_W'(b2da_pkg::VALUE_BITS);
            state     <= S_CONV;
          end
        end
        S_CONV: begin
          sreg      <= {sreg[b2da_pkg::VALUE_BITS-2:0], 1'b0};
          bits_left <= bits_left - b2da_pkg::BIT_CNT_W'(1);
          if (bits_left == b2da_pkg::BIT_CNT_W'(1)) begin
            digs_left <= b2da_pkg::DIG_CNT_W'(b2da_pkg::NUM_DIGITS);
            started   <= 1'b0;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            digs_left <= digs_left - b2da_pkg::DIG_CNT_W'(1);
            if (!skip) begin
              started     <= 1'b1;
              digit_valid <= 1'b1;
              digit_char  <= b2da_pkg::ASCII_ZERO + {2'b00, top_digit};
              last_digit  <= (digs_left == b2da_pkg::DIG_CNT_W'(1));
              if (digs_left == b2da_pkg::DIG_CNT_W'(1)) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
